[sv/heightfield_height_query_defines.svh]
// ---------------------------------------------------------------------------
// heightfield height query assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef HEIGHTFIELD_HEIGHT_QUERY_DEFINES_SVH
`define HEIGHTFIELD_HEIGHT_QUERY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HHQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HHQ_ASSERT(lbl, prop, msg)
`define HHQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[sv/hhq_pkg.sv]
// ---------------------------------------------------------------------------
// hhq_pkg
// shared types, codes and constants of the heightfield height query block
// ---------------------------------------------------------------------------
package hhq_pkg;

  localparam int NUM_W     = 48;  // divider dividend / quotient width
  localparam int DEN_W     = 23;  // divider divisor width
  localparam int SQ_IN_W   = 48;  // square root radicand width
  localparam int SQ_OUT_W  = 24;  // square root result width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  typedef logic signed [23:0] height_t;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BRUSH = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_DEPTH = 3'd4;

  // quarter cosine polynomial coefficients, Q16
  localparam logic [16:0] COS_K0 = 17'd60;
  localparam logic [16:0] COS_K1 = 17'd1367;
  localparam logic [16:0] COS_K2 = 17'd16624;
  localparam logic [16:0] COS_K3 = 17'd80852;
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  localparam logic signed [27:0] H_MAX = 28'sd8388607;
  localparam logic signed [27:0] H_MIN = -28'sd8388608;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sqrt_res_t;

  function automatic height_t sat_h(input logic signed [27:0] v);
    if (v > H_MAX) begin
      return H_MAX[23:0];
    end else if (v < H_MIN) begin
      return H_MIN[23:0];
    end
    return v[23:0];
  endfunction

endpackage

[sv/hhq_div.sv]
// ---------------------------------------------------------------------------
// hhq_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module hhq_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [hhq_pkg::NUM_W-1:0] num,
  input  logic [hhq_pkg::DEN_W-1:0] den,
  output hhq_pkg::div_res_t        res
);
  import hhq_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

[sv/hhq_sqrt.sv]
// ---------------------------------------------------------------------------
// hhq_sqrt
// integer square root, one result bit per cycle
// ---------------------------------------------------------------------------
module hhq_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hhq_pkg::SQ_IN_W-1:0] radicand,
  output hhq_pkg::sqrt_res_t         res
);
  import hhq_pkg::*;

  localparam int CW = $clog2(SQ_OUT_W);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [SQ_IN_W-1:0]  num_r;
  logic [SQ_OUT_W-1:0] rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [SQ_OUT_W+1:0] r2;
  logic [SQ_OUT_W+1:0] trial;
  logic                ge;

  assign r2    = {rem_r, num_r[SQ_IN_W-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? SQ_OUT_W'(r2 - trial) : SQ_OUT_W'(r2);
        root_r <= {root_r[SQ_OUT_W-2:0], ge};
        num_r  <= {num_r[SQ_IN_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CW'(SQ_OUT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.root = root_r;

endmodule

[sv/heightfield_height_query.sv]
// Load: the height is written into memory when the item is accepted; query: four divider runs (cell column,
// cell row, two interpolation terms share one divider) plus 4 height reads.
// Brush: a vertex out of reach is skipped after the axis or distance check; a vertex in reach
// takes square root, divider, cosine steps and a read-modify-write on the height memory.
// Throughput: one item at a time; the next item is taken when the current one finishes.
// Reset: memory cleared one entry a cycle over all (CELLS_X+1)*(CELLS_Z+1) entries, items stalled.
// ---------------------------------------------------------------------------
// heightfield_height_query
// vertex height grid with load, brush raise or lower and triangle height query
// ---------------------------------------------------------------------------
module heightfield_height_query #(
  parameter int CELLS_X = 16,
  parameter int CELLS_Z = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [8:0]                     in_vertex_index,
  input  logic signed [23:0]             in_height_value,
  input  logic signed [23:0]             in_pos_x,
  input  logic signed [23:0]             in_pos_z,
  input  logic [22:0]                    in_brush_radius,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [23:0]             out_height,
  output logic                           out_outside,
  input  logic                           cfg_wr_en,
  input  logic [hhq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hhq_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import hhq_pkg::*;

  `include "heightfield_height_query_defines.svh"

  localparam int COLS = CELLS_X + 1;
  localparam int NV   = COLS * (CELLS_Z + 1);
  localparam int AW   = $clog2(NV);
  localparam int CXW  = $clog2(CELLS_X + 1);
  localparam int CZW  = $clog2(CELLS_Z + 1);
  localparam int OW   = DEN_W + ((CXW > CZW) ? CXW : CZW);
  localparam int PW   = OW + 2;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE,
    ST_Q_CLAMP, ST_Q_DIVX, ST_Q_DIVZ,
    ST_Q_RD0, ST_Q_RD1, ST_Q_RD2, ST_Q_RD3, ST_Q_RD4,
    ST_Q_DIFF, ST_Q_M1, ST_Q_S1, ST_Q_W1, ST_Q_M2, ST_Q_S2, ST_Q_W2, ST_Q_OUT,
    ST_B_R2, ST_B_VTX, ST_B_SQX, ST_B_SQZ, ST_B_CMP, ST_B_SQRT, ST_B_DIV,
    ST_B_C0, ST_B_C1, ST_B_C2, ST_B_C3, ST_B_C4, ST_B_C5, ST_B_C6,
    ST_B_UPD, ST_B_NEXT
  } state_t;

  state_t st_r;

  // configuration
  logic signed [23:0] ox_r, oy_r, oz_r;
  logic [DEN_W-1:0]   cw_r, cd_r;
  logic [DEN_W-1:0]   cw_eff, cd_eff;

  // item registers
  logic signed [24:0] lx_r, lz_r;
  logic [23:0]        vmag_r;
  logic               vneg_r;
  logic [DEN_W-1:0]   rad_r;

  // query registers
  logic               outside_r;
  logic [OW-1:0]      zc_r;
  logic [CXW-1:0]     cx_r;
  logic [DEN_W-1:0]   fx_r, fz_r;
  logic [AW-1:0]      base_r;
  logic [45:0]        p1_r;
  logic               upper_r;
  height_t            hlu_r, hru_r, hld_r, hrd_r;
  logic signed [24:0] d1_r, d2_r;
  logic signed [50:0] prod_r;
  logic               neg_r;
  logic signed [25:0] t1_r, t2_r;

  // brush registers
  logic [CXW-1:0]     col_r;
  logic [CZW-1:0]     row_r;
  logic [OW-1:0]      xacc_r, zacc_r;
  logic [AW-1:0]      idx_r;
  logic [45:0]        r2_r;
  logic [46:0]        d2s_r;
  logic [DEN_W-1:0]   ax_r, az_r;
  logic [16:0]        t_r, u_r, s_r, cos_r;
  logic [23:0]        q_r;

  // output
  logic               out_valid_r;
  height_t            out_height_r;
  logic               out_outside_r;

  // memory
  height_t            mem [NV];
  height_t            rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  height_t            mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [AW-1:0]      clr_r;

  // shared multiplier
  logic signed [25:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [50:0] prod;

  // divider and square root
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  div_res_t           div_res;
  logic               sq_start;
  sqrt_res_t          sq_res;

  // combinational helpers
  logic               in_acc;
  logic [OW-1:0]      limx, limz;
  logic signed [PW-1:0] lxs, lzs, limx_s, limz_s;
  logic [OW-1:0]      xcl, zcl;
  logic               xout, zout;
  logic [DEN_W-1:0]   f1, f2, den1, den2;
  logic signed [50:0] pmag;
  logic signed [PW-1:0] dx, dz;
  logic [PW-1:0]      adx, adz;
  logic [CZW-1:0]     rz_v;
  logic [DEN_W-1:0]   fz_v;
  logic signed [27:0] qsum;
  logic signed [27:0] bsum;
  logic signed [18:0] cval;

  assign cw_eff = (cw_r == '0) ? DEN_W'(1) : cw_r;
  assign cd_eff = (cd_r == '0) ? DEN_W'(1) : cd_r;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);

  assign limx   = OW'(CELLS_X) * OW'(cw_eff);
  assign limz   = OW'(CELLS_Z) * OW'(cd_eff);
  assign lxs    = PW'(lx_r);
  assign lzs    = PW'(lz_r);
  assign limx_s = $signed({2'b00, limx});
  assign limz_s = $signed({2'b00, limz});

  always_comb begin
    xout = 1'b0;
    zout = 1'b0;
    if (lxs < 0) begin
      xcl  = '0;
      xout = 1'b1;
    end else if (lxs > limx_s) begin
      xcl  = limx;
      xout = 1'b1;
    end else begin
      xcl = OW'(lxs);
    end
    if (lzs < 0) begin
      zcl  = '0;
      zout = 1'b1;
    end else if (lzs > limz_s) begin
      zcl  = limz;
      zout = 1'b1;
    end else begin
      zcl = OW'(lzs);
    end
  end

  // triangle terms: upper-right uses x then z, lower-left z then x
  assign f1   = upper_r ? fx_r : fz_r;
  assign f2   = upper_r ? fz_r : fx_r;
  assign den1 = upper_r ? cw_eff : cd_eff;
  assign den2 = upper_r ? cd_eff : cw_eff;
  assign pmag = prod_r[50] ? -prod_r : prod_r;

  assign dx  = lxs - $signed({2'b00, xacc_r});
  assign dz  = lzs - $signed({2'b00, zacc_r});
  assign adx = dx[PW-1] ? PW'(-dx) : PW'(dx);
  assign adz = dz[PW-1] ? PW'(-dz) : PW'(dz);

  assign rz_v = (div_res.quo >= NUM_W'(CELLS_Z)) ? CZW'(CELLS_Z - 1) : CZW'(div_res.quo);
  assign fz_v = (div_res.quo >= NUM_W'(CELLS_Z)) ? div_res.rem + cd_eff : div_res.rem;

  assign qsum = 28'(hlu_r) + 28'(t1_r) + 28'(t2_r) + 28'(oy_r);
  assign bsum = vneg_r ? 28'(rdata_r) - 28'($signed({1'b0, q_r}))
                       : 28'(rdata_r) + 28'($signed({1'b0, q_r}));
  assign cval = $signed({2'b00, ONE_Q16}) - $signed({2'b00, prod[32:16]});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_Q_RD0: begin
        mul_a = $signed({3'b000, fz_r});
        mul_b = $signed({2'b00, cw_eff});
      end
      ST_Q_RD1: begin
        mul_a = $signed({3'b000, fx_r});
        mul_b = $signed({2'b00, cd_eff});
      end
      ST_Q_M1: begin
        mul_a = 26'(d1_r);
        mul_b = $signed({2'b00, f1});
      end
      ST_Q_M2: begin
        mul_a = 26'(d2_r);
        mul_b = $signed({2'b00, f2});
      end
      ST_B_R2: begin
        mul_a = $signed({3'b000, rad_r});
        mul_b = $signed({2'b00, rad_r});
      end
      ST_B_SQX: begin
        mul_a = $signed({3'b000, ax_r});
        mul_b = $signed({2'b00, ax_r});
      end
      ST_B_SQZ: begin
        mul_a = $signed({3'b000, az_r});
        mul_b = $signed({2'b00, az_r});
      end
      ST_B_C0: begin
        mul_a = $signed({9'd0, t_r});
        mul_b = $signed({8'd0, t_r});
      end
      ST_B_C2, ST_B_C3, ST_B_C4, ST_B_C5: begin
        mul_a = $signed({9'd0, u_r});
        mul_b = $signed({8'd0, s_r});
      end
      ST_B_C6: begin
        mul_a = $signed({2'b00, vmag_r});
        mul_b = $signed({8'd0, cos_r});
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st_r)
      ST_Q_CLAMP: begin
        div_start = 1'b1;
        div_num   = NUM_W'(xcl);
        div_den   = cw_eff;
      end
      ST_Q_DIVX: begin
        div_start = div_res.done;
        div_num   = NUM_W'(zc_r);
        div_den   = cd_eff;
      end
      ST_Q_S1: begin
        div_start = 1'b1;
        div_num   = NUM_W'(pmag) + NUM_W'(den1 >> 1);
        div_den   = den1;
      end
      ST_Q_S2: begin
        div_start = 1'b1;
        div_num   = NUM_W'(pmag) + NUM_W'(den2 >> 1);
        div_den   = den2;
      end
      ST_B_SQRT: begin
        div_start = sq_res.done;
        div_num   = NUM_W'({sq_res.root, 16'd0});
        div_den   = rad_r;
      end
      default: begin
      end
    endcase
  end

  assign sq_start = (st_r == ST_B_CMP) && !(d2s_r > 47'(r2_r));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = sat_h(bsum);
    unique case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_we    = in_acc && (in_mode == MODE_LOAD) && (32'(in_vertex_index) < NV);
        mem_waddr = AW'(in_vertex_index);
        mem_wdata = in_height_value;
      end
      ST_B_UPD: mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    case (st_r)
      ST_Q_RD1: mem_raddr = base_r + AW'(1);
      ST_Q_RD2: mem_raddr = base_r + AW'(COLS);
      ST_Q_RD3: mem_raddr = base_r + AW'(COLS + 1);
      ST_B_C6:  mem_raddr = idx_r;
      default:  mem_raddr = base_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
      oz_r <= '0;
      cw_r <= DEN_W'(256);
      cd_r <= DEN_W'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ORIGIN_X:   ox_r <= cfg_wdata;
        REG_ORIGIN_Y:   oy_r <= cfg_wdata;
        REG_ORIGIN_Z:   oz_r <= cfg_wdata;
        REG_CELL_WIDTH: cw_r <= cfg_wdata[DEN_W-1:0];
        REG_CELL_DEPTH: cd_r <= cfg_wdata[DEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a finishing query loads the next beat itself
      if (out_valid_r && !out_stall && st_r != ST_Q_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NV - 1)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            lx_r   <= 25'(in_pos_x) - 25'(ox_r);
            lz_r   <= 25'(oz_r) - 25'(in_pos_z);
            vneg_r <= in_height_value[23];
            vmag_r <= in_height_value[23] ? 24'(-in_height_value) : 24'(in_height_value);
            rad_r  <= in_brush_radius;
            if (in_mode == MODE_QUERY) begin
              st_r <= ST_Q_CLAMP;
            end else if (in_mode == MODE_BRUSH && in_brush_radius != '0) begin
              st_r <= ST_B_R2;
            end
          end
        end
        ST_Q_CLAMP: begin
          zc_r      <= zcl;
          outside_r <= xout || zout;
          st_r      <= ST_Q_DIVX;
        end
        ST_Q_DIVX: begin
          if (div_res.done) begin
            // point on the far edge stays in the last cell
            if (div_res.quo >= NUM_W'(CELLS_X)) begin
              cx_r <= CXW'(CELLS_X - 1);
              fx_r <= div_res.rem + cw_eff;
            end else begin
              cx_r <= CXW'(div_res.quo);
              fx_r <= div_res.rem;
            end
            st_r <= ST_Q_DIVZ;
          end
        end
        ST_Q_DIVZ: begin
          if (div_res.done) begin
            fz_r   <= fz_v;
            base_r <= AW'(rz_v) * AW'(COLS) + AW'(cx_r);
            st_r   <= ST_Q_RD0;
          end
        end
        ST_Q_RD0: begin
          p1_r <= prod[45:0];
          st_r <= ST_Q_RD1;
        end
        ST_Q_RD1: begin
          upper_r <= (p1_r <= prod[45:0]);
          hlu_r   <= rdata_r;
          st_r    <= ST_Q_RD2;
        end
        ST_Q_RD2: begin
          hru_r <= rdata_r;
          st_r  <= ST_Q_RD3;
        end
        ST_Q_RD3: begin
          hld_r <= rdata_r;
          st_r  <= ST_Q_RD4;
        end
        ST_Q_RD4: begin
          hrd_r <= rdata_r;
          st_r  <= ST_Q_DIFF;
        end
        ST_Q_DIFF: begin
          d1_r <= upper_r ? 25'(hru_r) - 25'(hlu_r) : 25'(hld_r) - 25'(hlu_r);
          d2_r <= upper_r ? 25'(hrd_r) - 25'(hru_r) : 25'(hrd_r) - 25'(hld_r);
          st_r <= ST_Q_M1;
        end
        ST_Q_M1: begin
          prod_r <= prod;
          st_r   <= ST_Q_S1;
        end
        ST_Q_S1: begin
          neg_r <= prod_r[50];
          st_r  <= ST_Q_W1;
        end
        ST_Q_W1: begin
          if (div_res.done) begin
            t1_r <= neg_r ? -26'(div_res.quo) : 26'(div_res.quo);
            st_r <= ST_Q_M2;
          end
        end
        ST_Q_M2: begin
          prod_r <= prod;
          st_r   <= ST_Q_S2;
        end
        ST_Q_S2: begin
          neg_r <= prod_r[50];
          st_r  <= ST_Q_W2;
        end
        ST_Q_W2: begin
          if (div_res.done) begin
            t2_r <= neg_r ? -26'(div_res.quo) : 26'(div_res.quo);
            st_r <= ST_Q_OUT;
          end
        end
        ST_Q_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_height_r  <= sat_h(qsum);
            out_outside_r <= outside_r;
            st_r          <= ST_IDLE;
          end
        end
        ST_B_R2: begin
          r2_r   <= prod[45:0];
          col_r  <= '0;
          row_r  <= '0;
          xacc_r <= '0;
          zacc_r <= '0;
          idx_r  <= '0;
          st_r   <= ST_B_VTX;
        end
        ST_B_VTX: begin
          ax_r <= DEN_W'(adx);
          az_r <= DEN_W'(adz);
          // beyond the radius along one axis means beyond it in distance
          if (adx > PW'(rad_r) || adz > PW'(rad_r)) begin
            st_r <= ST_B_NEXT;
          end else begin
            st_r <= ST_B_SQX;
          end
        end
        ST_B_SQX: begin
          d2s_r <= 47'(prod[45:0]);
          st_r  <= ST_B_SQZ;
        end
        ST_B_SQZ: begin
          d2s_r <= d2s_r + 47'(prod[45:0]);
          st_r  <= ST_B_CMP;
        end
        ST_B_CMP: begin
          st_r <= sq_start ? ST_B_SQRT : ST_B_NEXT;
        end
        ST_B_SQRT: begin
          if (sq_res.done) begin
            st_r <= ST_B_DIV;
          end
        end
        ST_B_DIV: begin
          if (div_res.done) begin
            t_r  <= (div_res.quo > NUM_W'(ONE_Q16)) ? ONE_Q16 : 17'(div_res.quo);
            st_r <= ST_B_C0;
          end
        end
        ST_B_C0: begin
          u_r  <= prod[32:16];
          st_r <= ST_B_C1;
        end
        ST_B_C1: begin
          s_r  <= COS_K0 - {15'd0, u_r[16:15]};
          st_r <= ST_B_C2;
        end
        ST_B_C2: begin
          s_r  <= COS_K1 - prod[32:16];
          st_r <= ST_B_C3;
        end
        ST_B_C3: begin
          s_r  <= COS_K2 - prod[32:16];
          st_r <= ST_B_C4;
        end
        ST_B_C4: begin
          s_r  <= COS_K3 - prod[32:16];
          st_r <= ST_B_C5;
        end
        ST_B_C5: begin
          cos_r <= cval[18] ? '0 : cval[16:0];
          st_r  <= ST_B_C6;
        end
        ST_B_C6: begin
          // rounded half up on the magnitude
          q_r  <= 24'((prod[39:0] + 40'(HALF_Q16)) >> 16);
          st_r <= ST_B_UPD;
        end
        ST_B_UPD: begin
          st_r <= ST_B_NEXT;
        end
        ST_B_NEXT: begin
          if (col_r == CXW'(CELLS_X)) begin
            col_r  <= '0;
            xacc_r <= '0;
            if (row_r == CZW'(CELLS_Z)) begin
              st_r <= ST_IDLE;
            end else begin
              row_r  <= row_r + CZW'(1);
              zacc_r <= zacc_r + OW'(cd_eff);
              idx_r  <= idx_r + AW'(1);
              st_r   <= ST_B_VTX;
            end
          end else begin
            col_r  <= col_r + CXW'(1);
            xacc_r <= xacc_r + OW'(cw_eff);
            idx_r  <= idx_r + AW'(1);
            st_r   <= ST_B_VTX;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  hhq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  hhq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (SQ_IN_W'(d2s_r)),
    .res      (sq_res)
  );

  assign out_valid   = out_valid_r;
  assign out_height  = out_height_r;
  assign out_outside = out_outside_r;

  `HHQ_ASSERT(a_clear_stall, (st_r == ST_CLEAR) |-> in_stall, "beat taken during clearing pass")
  `HHQ_ASSERT(a_div_free, div_start |-> !div_res.busy, "divider started while busy")
  `HHQ_ASSERT(a_wr_range, mem_we |-> (32'(mem_waddr) < NV), "height write out of range")
  `HHQ_ASSERT_NEXT(a_out_src, (!out_valid_r && st_r != ST_Q_OUT), !out_valid_r,
    "result raised outside query finish")

endmodule
